// ===== rtl/core/accc_pkg.sv =====
// Shared constants, word types and control types for the affine cycle closure checker.
`default_nettype none

package accc_pkg;

	localparam int MOD_BITS = 15;
	localparam int COEF_W   = 15;
	localparam int DVD_W    = (2 * MOD_BITS > COEF_W) ? 2 * MOD_BITS : COEF_W;
	localparam int CNT_W    = $clog2(DVD_W + 1);
	localparam int T_W      = MOD_BITS + 2;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;

	localparam logic [PADDR_W-3:0]  REG_MODULUS = '0;
	localparam logic [MOD_BITS-1:0] MOD_RESET   = MOD_BITS'(2);
	localparam logic [MOD_BITS-1:0] MOD_MIN     = MOD_BITS'(2);

	typedef struct packed {
		logic              family;
		logic [COEF_W-1:0] coef_a;
		logic [COEF_W-1:0] coef_b;
		logic              last;
	} in_word_t;

	typedef struct packed {
		logic closed;
		logic error;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EUC_INIT,
		ST_EUC_TEST,
		ST_EUC_MUL,
		ST_EUC_UPD,
		ST_INV_FIX,
		ST_MUL,
		ST_ADVANCE,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		STEP_A,
		STEP_B,
		STEP_M,
		STEP_D,
		STEP_EUC,
		STEP_GCD,
		STEP_FB,
		STEP_NA,
		STEP_NB,
		STEP_FIN
	} step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_GO,
		OP_DIV_TAKE,
		OP_EUC_INIT,
		OP_EUC_MUL,
		OP_EUC_UPD,
		OP_SET_ERR,
		OP_INV_FIX,
		OP_MUL,
		OP_ADVANCE,
		OP_CLOSE_TRIV,
		OP_GCD_INIT,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t   op;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic r1_zero;
		logic r0_one;
		logic inverted;
		logic last;
		logic mul_one;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/accc_div.sv =====
// Shift-subtract divider, one quotient bit per cycle, shared by every reduction.
`default_nettype none

module accc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [accc_pkg::DVD_W-1:0]    dvd,
	input  wire logic [accc_pkg::CNT_W-1:0]    len,
	input  wire logic [accc_pkg::MOD_BITS-1:0] dsr,
	output logic                               done,
	output logic [accc_pkg::MOD_BITS-1:0]      quot,
	output logic [accc_pkg::MOD_BITS-1:0]      rem
);

	localparam int W  = accc_pkg::MOD_BITS;
	localparam int DW = accc_pkg::DVD_W;
	localparam int CW = accc_pkg::CNT_W;

	logic [DW-1:0] dvd_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= len;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			rem_q <= '0;
			dsr_q <= dsr;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q[W-1:0];
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/accc_dp.sv =====
// Datapath: composite, Euclid registers, multiplier, divider and result word.
`default_nettype none

module accc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [accc_pkg::MOD_BITS-1:0] modulus,
	input  wire accc_pkg::in_word_t            item,
	input  wire accc_pkg::cmd_t                cmd,
	output accc_pkg::stat_t                    stat,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output accc_pkg::out_word_t                result
);

	localparam int W  = accc_pkg::MOD_BITS;
	localparam int DW = accc_pkg::DVD_W;
	localparam int CW = accc_pkg::CNT_W;
	localparam int TW = accc_pkg::T_W;
	localparam int CF = accc_pkg::COEF_W;

	localparam logic [CW-1:0] LEN_COEF = CW'(CF);
	localparam logic [CW-1:0] LEN_RES  = CW'(W);
	localparam logic [CW-1:0] LEN_PROD = CW'(2 * W);

	accc_pkg::in_word_t  item_q;
	accc_pkg::out_word_t result_q;

	logic [W-1:0]          p_q;
	logic [W-1:0]          fa_q;
	logic [W-1:0]          fb_q;
	logic [W-1:0]          tmp_q;
	logic [W-1:0]          r0_q;
	logic [W-1:0]          r1_q;
	logic signed [TW-1:0]  t0_q;
	logic signed [TW-1:0]  t1_q;
	logic signed [TW-1:0]  qt_q;
	logic [2*W-1:0]        prod_q;
	logic [W-1:0]          acc_mul_q;
	logic [W-1:0]          acc_add_q;
	logic                  odd_q;
	logic                  err_q;
	logic                  closed_q;
	logic                  res_valid_q;

	logic [DW-1:0]         div_dvd;
	logic [CW-1:0]         div_len;
	logic [W-1:0]          div_dsr;
	logic                  div_done;
	logic [W-1:0]          div_quot;
	logic [W-1:0]          div_rem;

	logic [W-1:0]          mul_a;
	logic [W-1:0]          mul_b;
	logic signed [W+TW:0]  qt_full;
	logic signed [TW-1:0]  p_ext;
	logic signed [TW-1:0]  t_pos;
	logic signed [TW-1:0]  t_fix;
	logic [W:0]            nb_sum;
	logic [W:0]            nb_diff;
	logic [W-1:0]          nb_red;
	logic [W-1:0]          fb_neg;
	logic [W-1:0]          gcd_x;
	logic [W-1:0]          p_eff;
	logic                  out_free;

	always_comb begin
		div_dvd = '0;
		div_len = LEN_RES;
		div_dsr = p_q;
		mul_a   = acc_mul_q;
		mul_b   = fa_q;
		unique case (cmd.step)
			accc_pkg::STEP_A: begin
				div_dvd = DW'(item_q.coef_a) << (DW - CF);
				div_len = LEN_COEF;
			end
			accc_pkg::STEP_B: begin
				div_dvd = DW'(item_q.coef_b) << (DW - CF);
				div_len = LEN_COEF;
			end
			accc_pkg::STEP_M: begin
				div_dvd = DW'(acc_mul_q) << (DW - W);
			end
			accc_pkg::STEP_D: begin
				div_dvd = DW'(acc_add_q) << (DW - W);
			end
			accc_pkg::STEP_EUC, accc_pkg::STEP_GCD: begin
				div_dvd = DW'(r0_q) << (DW - W);
				div_dsr = r1_q;
			end
			accc_pkg::STEP_FB: begin
				div_dvd = DW'(prod_q) << (DW - 2 * W);
				div_len = LEN_PROD;
				mul_a   = fa_q;
				mul_b   = fb_q;
			end
			accc_pkg::STEP_NA: begin
				div_dvd = DW'(prod_q) << (DW - 2 * W);
				div_len = LEN_PROD;
			end
			accc_pkg::STEP_NB: begin
				div_dvd = DW'(prod_q) << (DW - 2 * W);
				div_len = LEN_PROD;
				mul_b   = fb_q;
			end
			accc_pkg::STEP_FIN: begin
				div_dvd = DW'(acc_add_q) << (DW - W);
				div_dsr = r0_q;
			end
			default: begin
				div_dvd = '0;
			end
		endcase
	end

	accc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == accc_pkg::OP_DIV_GO),
		.dvd    (div_dvd),
		.len    (div_len),
		.dsr    (div_dsr),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_comb begin
		qt_full = $signed({1'b0, div_quot}) * t1_q;
		p_ext   = $signed({2'b00, p_q});
		t_pos   = t0_q[TW-1] ? t0_q + p_ext : t0_q;
		t_fix   = (t_pos >= p_ext) ? t_pos - p_ext : t_pos;
		nb_sum  = {1'b0, div_rem} + {1'b0, acc_add_q};
		nb_diff = nb_sum - {1'b0, p_q};
		nb_red  = (nb_sum >= {1'b0, p_q}) ? nb_diff[W-1:0] : nb_sum[W-1:0];
		fb_neg  = (div_rem == '0) ? '0 : p_q - div_rem;
		gcd_x   = (acc_mul_q == '0) ? p_q - W'(1) : acc_mul_q - W'(1);
		p_eff   = (modulus < accc_pkg::MOD_MIN) ? accc_pkg::MOD_MIN : modulus;
		out_free = !res_valid_q || result_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mul_q   <= W'(1);
			acc_add_q   <= '0;
			odd_q       <= 1'b0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.op == accc_pkg::OP_EMIT) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				accc_pkg::OP_DIV_TAKE: begin
					if (cmd.step == accc_pkg::STEP_M) begin
						acc_mul_q <= div_rem;
					end
					if (cmd.step == accc_pkg::STEP_D) begin
						acc_add_q <= div_rem;
					end
					if (cmd.step == accc_pkg::STEP_NB) begin
						acc_mul_q <= tmp_q;
						acc_add_q <= nb_red;
					end
				end
				accc_pkg::OP_SET_ERR: begin
					err_q <= 1'b1;
				end
				accc_pkg::OP_ADVANCE: begin
					odd_q <= ~odd_q;
				end
				accc_pkg::OP_EMIT: begin
					acc_mul_q <= W'(1);
					acc_add_q <= '0;
					odd_q     <= 1'b0;
					err_q     <= 1'b0;
				end
				default: begin
					odd_q <= odd_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			accc_pkg::OP_LOAD: begin
				item_q <= item;
				p_q    <= p_eff;
			end
			accc_pkg::OP_DIV_TAKE: begin
				unique case (cmd.step)
					accc_pkg::STEP_A:   fa_q     <= div_rem;
					accc_pkg::STEP_B:   fb_q     <= div_rem;
					accc_pkg::STEP_FB:  fb_q     <= fb_neg;
					accc_pkg::STEP_NA:  tmp_q    <= div_rem;
					accc_pkg::STEP_FIN: closed_q <= (div_rem == '0);
					default:            tmp_q    <= tmp_q;
				endcase
			end
			accc_pkg::OP_EUC_INIT: begin
				r0_q <= p_q;
				r1_q <= fa_q;
				t0_q <= '0;
				t1_q <= TW'(1);
			end
			accc_pkg::OP_GCD_INIT: begin
				r0_q <= p_q;
				r1_q <= gcd_x;
				t0_q <= '0;
				t1_q <= TW'(1);
			end
			accc_pkg::OP_EUC_MUL: begin
				qt_q <= qt_full[TW-1:0];
			end
			accc_pkg::OP_EUC_UPD: begin
				r0_q <= r1_q;
				r1_q <= div_rem;
				t0_q <= t1_q;
				t1_q <= t0_q - qt_q;
			end
			accc_pkg::OP_INV_FIX: begin
				fa_q <= t_fix[W-1:0];
			end
			accc_pkg::OP_MUL: begin
				prod_q <= (2 * W)'(mul_a) * (2 * W)'(mul_b);
			end
			accc_pkg::OP_CLOSE_TRIV: begin
				closed_q <= (acc_add_q == '0);
			end
			accc_pkg::OP_EMIT: begin
				result_q.closed <= closed_q;
				result_q.error  <= err_q;
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	always_comb begin
		stat.div_done = div_done;
		stat.r1_zero  = (r1_q == '0);
		stat.r0_one   = (r0_q == W'(1));
		stat.inverted = (item_q.family != odd_q);
		stat.last     = item_q.last;
		stat.mul_one  = (acc_mul_q == W'(1));
		stat.out_free = out_free;
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/accc_ctrl.sv =====
// Controller: sequences reductions, Euclid steps, composition and the closure test.
`default_nettype none

module accc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire accc_pkg::stat_t stat,
	output accc_pkg::cmd_t       cmd
);

	accc_pkg::state_t state_q;
	accc_pkg::state_t state_d;
	accc_pkg::step_t  step_q;
	accc_pkg::step_t  step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= accc_pkg::ST_IDLE;
			step_q  <= accc_pkg::STEP_A;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			accc_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = accc_pkg::ST_DIV_GO;
					step_d  = accc_pkg::STEP_A;
				end
			end
			accc_pkg::ST_DIV_GO: begin
				state_d = accc_pkg::ST_DIV_WAIT;
			end
			accc_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) begin
					unique case (step_q)
						accc_pkg::STEP_A: begin
							step_d  = accc_pkg::STEP_B;
							state_d = accc_pkg::ST_DIV_GO;
						end
						accc_pkg::STEP_B: begin
							step_d  = accc_pkg::STEP_M;
							state_d = accc_pkg::ST_DIV_GO;
						end
						accc_pkg::STEP_M: begin
							step_d  = accc_pkg::STEP_D;
							state_d = accc_pkg::ST_DIV_GO;
						end
						accc_pkg::STEP_D: begin
							if (stat.inverted) begin
								state_d = accc_pkg::ST_EUC_INIT;
							end else begin
								step_d  = accc_pkg::STEP_NA;
								state_d = accc_pkg::ST_MUL;
							end
						end
						accc_pkg::STEP_EUC, accc_pkg::STEP_GCD: begin
							state_d = accc_pkg::ST_EUC_MUL;
						end
						accc_pkg::STEP_FB: begin
							step_d  = accc_pkg::STEP_NA;
							state_d = accc_pkg::ST_MUL;
						end
						accc_pkg::STEP_NA: begin
							step_d  = accc_pkg::STEP_NB;
							state_d = accc_pkg::ST_MUL;
						end
						accc_pkg::STEP_NB: begin
							state_d = accc_pkg::ST_ADVANCE;
						end
						accc_pkg::STEP_FIN: begin
							state_d = accc_pkg::ST_OUT;
						end
						default: begin
							state_d = accc_pkg::ST_IDLE;
						end
					endcase
				end
			end
			accc_pkg::ST_EUC_INIT: begin
				step_d  = accc_pkg::STEP_EUC;
				state_d = accc_pkg::ST_EUC_TEST;
			end
			accc_pkg::ST_EUC_TEST: begin
				priority if (!stat.r1_zero) begin
					state_d = accc_pkg::ST_DIV_GO;
				end else if (step_q == accc_pkg::STEP_GCD) begin
					step_d  = accc_pkg::STEP_FIN;
					state_d = accc_pkg::ST_DIV_GO;
				end else if (stat.r0_one) begin
					state_d = accc_pkg::ST_INV_FIX;
				end else begin
					state_d = accc_pkg::ST_ADVANCE;
				end
			end
			accc_pkg::ST_EUC_MUL: begin
				state_d = accc_pkg::ST_EUC_UPD;
			end
			accc_pkg::ST_EUC_UPD: begin
				state_d = accc_pkg::ST_EUC_TEST;
			end
			accc_pkg::ST_INV_FIX: begin
				step_d  = accc_pkg::STEP_FB;
				state_d = accc_pkg::ST_MUL;
			end
			accc_pkg::ST_MUL: begin
				state_d = accc_pkg::ST_DIV_GO;
			end
			accc_pkg::ST_ADVANCE: begin
				priority if (!stat.last) begin
					state_d = accc_pkg::ST_IDLE;
				end else if (stat.mul_one) begin
					state_d = accc_pkg::ST_OUT;
				end else begin
					step_d  = accc_pkg::STEP_GCD;
					state_d = accc_pkg::ST_EUC_TEST;
				end
			end
			accc_pkg::ST_OUT: begin
				if (stat.out_free) begin
					state_d = accc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = accc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.step   = step_q;
		cmd.op     = accc_pkg::OP_NONE;
		item_ready = 1'b0;
		unique case (state_q)
			accc_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.op = accc_pkg::OP_LOAD;
				end
			end
			accc_pkg::ST_DIV_GO: begin
				cmd.op = accc_pkg::OP_DIV_GO;
			end
			accc_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.op = accc_pkg::OP_DIV_TAKE;
				end
			end
			accc_pkg::ST_EUC_INIT: begin
				cmd.op = accc_pkg::OP_EUC_INIT;
			end
			accc_pkg::ST_EUC_TEST: begin
				if (stat.r1_zero && step_q == accc_pkg::STEP_EUC && !stat.r0_one) begin
					cmd.op = accc_pkg::OP_SET_ERR;
				end
			end
			accc_pkg::ST_EUC_MUL: begin
				cmd.op = accc_pkg::OP_EUC_MUL;
			end
			accc_pkg::ST_EUC_UPD: begin
				cmd.op = accc_pkg::OP_EUC_UPD;
			end
			accc_pkg::ST_INV_FIX: begin
				cmd.op = accc_pkg::OP_INV_FIX;
			end
			accc_pkg::ST_MUL: begin
				cmd.op = accc_pkg::OP_MUL;
			end
			accc_pkg::ST_ADVANCE: begin
				priority if (!stat.last) begin
					cmd.op = accc_pkg::OP_ADVANCE;
				end else if (stat.mul_one) begin
					cmd.op = accc_pkg::OP_CLOSE_TRIV;
				end else begin
					cmd.op = accc_pkg::OP_GCD_INIT;
				end
			end
			accc_pkg::ST_OUT: begin
				if (stat.out_free) begin
					cmd.op = accc_pkg::OP_EMIT;
				end
			end
			default: begin
				cmd.op = accc_pkg::OP_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/affine_cycle_closure_check.sv =====
// Top level: register port, controller and datapath of the affine cycle closure checker.
//
// One word is taken at a time. A node composed directly reduces its coefficients, the
// composite multiplier and addend, then multiplies and reduces the products; a node
// composed as its inverse adds extended-Euclid steps (at most 21 steps for a 15-bit
// modulus), the inverse fix and one more product; the last node of a cycle adds the
// gcd test, which is skipped when the composite multiplier is already one. Every step
// uses the one shared shift-subtract divider, which retires one quotient bit per cycle.
// The result word sits in an output register, so the next word is taken while it
// waits; a second result holds the controller until the first has left.
`default_nettype none

module affine_cycle_closure_check (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [accc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [accc_pkg::DATA_W-1:0]  pwdata,
	output logic [accc_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire accc_pkg::in_word_t           item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output accc_pkg::out_word_t               result
);

	localparam int W  = accc_pkg::MOD_BITS;
	localparam int DW = accc_pkg::DATA_W;
	localparam int AW = accc_pkg::PADDR_W;

	logic [W-1:0]    mod_q;
	logic            reg_hit;
	accc_pkg::cmd_t  cmd;
	accc_pkg::stat_t stat;

	assign reg_hit = (paddr[AW-1:2] == accc_pkg::REG_MODULUS);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DW'(mod_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= accc_pkg::MOD_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mod_q <= pwdata[W-1:0];
		end
	end

	accc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	accc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.modulus      (mod_q),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
